// ===== rtl/mec_pkg.sv =====
// Package for the Mandelbrot escape counter: widths, defaults, microcode.
// Holds the control word type and the read-only sequencer program.
// No dependencies.
package mec_pkg;

  localparam int FRAC_BITS_DEF   = 27;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int ITER_W          = 16;
  localparam int TOTAL_W         = 32;
  localparam int PROD_W          = 2 * DATA_W;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(1024);

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // program steps
  localparam step_t S_IDLE = 3'd0;
  localparam step_t S_MRR  = 3'd1;
  localparam step_t S_MII  = 3'd2;
  localparam step_t S_MRI  = 3'd3;
  localparam step_t S_TEST = 3'd4;
  localparam step_t S_UPD  = 3'd5;
  localparam step_t S_DONE = 3'd6;

  // multiplier operand select
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_RR   = 2'd1;
  localparam logic [1:0] MUL_II   = 2'd2;
  localparam logic [1:0] MUL_RI   = 2'd3;

  // product capture
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_RR   = 2'd1;
  localparam logic [1:0] CAP_II   = 2'd2;

  // sequencing
  localparam logic [2:0] BR_NEXT     = 3'd0;
  localparam logic [2:0] BR_WAIT_IN  = 3'd1;
  localparam logic [2:0] BR_TEST     = 3'd2;
  localparam logic [2:0] BR_JUMP     = 3'd3;
  localparam logic [2:0] BR_WAIT_OUT = 3'd4;

  typedef struct packed {
    logic [1:0] mul;
    logic [1:0] cap;
    logic [2:0] br;
    logic       upd;
    step_t      target;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{mul: MUL_NONE, cap: CAP_NONE, br: BR_NEXT, upd: 1'b0, target: S_IDLE};
    case (step)
      S_IDLE: begin
        w.br     = BR_WAIT_IN;
        w.target = S_MRR;
      end
      S_MRR: begin
        w.mul = MUL_RR;
      end
      S_MII: begin
        w.mul = MUL_II;
        w.cap = CAP_RR;
      end
      S_MRI: begin
        w.mul = MUL_RI;
        w.cap = CAP_II;
      end
      S_TEST: begin
        w.br     = BR_TEST;
        w.target = S_DONE;
      end
      S_UPD: begin
        w.upd    = 1'b1;
        w.br     = BR_JUMP;
        w.target = S_MRR;
      end
      S_DONE: begin
        w.br     = BR_WAIT_OUT;
        w.target = S_IDLE;
      end
      default: begin
        w.br     = BR_JUMP;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mandelbrot_escape_counter_top.sv =====
// Each iteration is five microcode steps around one shared 32x32 multiplier (three products,
// test, update). A new point is accepted only while the sequencer is idle, and a pending
// result that is stalled holds the sequencer in its done step.
// Reset (rst_n low, synchronous): limit 1024, outside count and z state zero,
// sequencer idle, no result pending.
// Top level of the Mandelbrot escape counter; uses mec_pkg.
module mandelbrot_escape_counter_top
  import mec_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ITER_W-1:0]        cfg_max_iterations,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_c_re,
  input  logic signed [DATA_W-1:0] in_c_im,
  input  logic                     in_clear_count,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_escaped,
  output logic [ITER_W-1:0]        out_iterations_done,
  output logic [TOTAL_W-1:0]       out_outside_total
);

  localparam logic [PROD_W-1:0] FOUR = PROD_W'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  step_t                     step_r, step_nxt;
  ctrl_t                     cw;
  logic [ITER_W-1:0]         max_r;
  logic signed [DATA_W-1:0]  cr_r, ci_r, zr_r, zi_r;
  logic [ITER_W-1:0]         n_r;
  logic signed [PROD_W-1:0]  prod_r, rr_r, ii_r, diff_r;
  logic                      esc_r;
  logic [COUNT_WIDTH-1:0]    cnt_r, cnt_inc;
  logic                      out_valid_r, out_esc_r;
  logic [ITER_W-1:0]         out_iter_r;
  logic [TOTAL_W-1:0]        out_total_r, total_clamp;

  logic                      in_xfer, out_take, esc_now, lim_now;
  logic signed [DATA_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod, sum_re, sum_im;
  logic [PROD_W-1:0]         mag2;

  assign cw        = ucode(step_r);
  assign cfg_ready = 1'b1;
  assign in_stall  = (step_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_take  = (step_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    case (cw.mul)
      MUL_RR:  begin mul_a = zr_r; mul_b = zr_r; end
      MUL_II:  begin mul_a = zi_r; mul_b = zi_r; end
      MUL_RI:  begin mul_a = zr_r; mul_b = zi_r; end
      default: begin mul_a = zr_r; mul_b = zr_r; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign mag2    = PROD_W'(rr_r) + PROD_W'(ii_r);
  assign esc_now = (n_r != '0) && (mag2 > FOUR);
  assign lim_now = (n_r == max_r);

  // floor shifts, then add c; prod_r holds zr*zi during the update step
  assign sum_re = (diff_r >>> FRAC_BITS) + PROD_W'(cr_r);
  assign sum_im = (prod_r >>> (FRAC_BITS - 1)) + PROD_W'(ci_r);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    if (x > SAT_HI) return DATA_W'(SAT_HI);
    if (x < SAT_LO) return DATA_W'(SAT_LO);
    return x[DATA_W-1:0];
  endfunction

  assign cnt_inc = (esc_r && (cnt_r != '1)) ? cnt_r + COUNT_WIDTH'(1) : cnt_r;

  generate
    if (COUNT_WIDTH > TOTAL_W) begin : g_clamp
      assign total_clamp = (|cnt_inc[COUNT_WIDTH-1:TOTAL_W]) ? '1 : cnt_inc[TOTAL_W-1:0];
    end else begin : g_ext
      assign total_clamp = TOTAL_W'(cnt_inc);
    end
  endgenerate

  always_comb begin
    step_nxt = step_r;
    case (cw.br)
      BR_NEXT:     step_nxt = step_r + STEP_W'(1);
      BR_WAIT_IN:  if (in_xfer) step_nxt = cw.target;
      BR_TEST: begin
        if (esc_now || lim_now) step_nxt = cw.target;
        else step_nxt = step_r + STEP_W'(1);
      end
      BR_JUMP:     step_nxt = cw.target;
      BR_WAIT_OUT: if (out_take) step_nxt = cw.target;
      default:     step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      max_r       <= MAX_ITER_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      zr_r        <= '0;
      zi_r        <= '0;
      n_r         <= '0;
    end else begin
      step_r <= step_nxt;
      if (cfg_valid && cfg_ready) max_r <= cfg_max_iterations;
      if (in_xfer) begin
        cr_r <= in_c_re;
        ci_r <= in_c_im;
        zr_r <= in_c_re;
        zi_r <= in_c_im;
        n_r  <= '0;
        if (in_clear_count) cnt_r <= '0;
      end
      if (cw.mul != MUL_NONE) prod_r <= prod;
      if (cw.cap == CAP_RR) rr_r <= prod_r;
      if (cw.cap == CAP_II) ii_r <= prod_r;
      if (cw.br == BR_TEST) begin
        esc_r  <= esc_now;
        diff_r <= rr_r - ii_r;
      end
      if (cw.upd) begin
        zr_r <= sat32(sum_re);
        zi_r <= sat32(sum_im);
        n_r  <= n_r + ITER_W'(1);
      end
      if (out_take) begin
        cnt_r       <= cnt_inc;
        out_valid_r <= 1'b1;
        out_esc_r   <= esc_r;
        out_iter_r  <= n_r;
        out_total_r <= total_clamp;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_escaped         = out_esc_r;
  assign out_iterations_done = out_iter_r;
  assign out_outside_total   = out_total_r;

endmodule
